### hdl/pbec_pkg.sv
package pbec_pkg;

  // Field widths
  localparam int COORD_W    = 14;
  localparam int CH_W       = 20;
  localparam int OFS_W      = 18;
  localparam int PER_W      = 15;
  localparam int WID_W      = 15;
  localparam int FTH_W      = 13;
  localparam int GAIN_W     = 21;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;

  // Stream packing
  localparam int IN_W  = 88;
  localparam int OUT_W = 64;
  localparam int RGB_W = 3 * CH_W;

  // Weight is unsigned Q0.16 with one extra bit for exactly one
  localparam int W_FRAC = 16;
  localparam int Q_W    = W_FRAC + 1;
  localparam logic [Q_W-1:0] W_ONE = Q_W'(1 << W_FRAC);
  localparam logic signed [GAIN_W:0] GAIN_ONE = (GAIN_W + 1)'(1 << W_FRAC);

  // w * (gain - 1): 18 x 22 bit signed product
  localparam int P_W = Q_W + 1 + GAIN_W + 1;

  // Iterative units resolve this many bits per pipeline stage
  localparam int STEPS_PER_ST = 3;
  localparam int DIV_ST       = (Q_W + STEPS_PER_ST - 1) / STEPS_PER_ST;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIENT  = 3'd0,
    REG_OFFSET  = 3'd1,
    REG_PERIOD  = 3'd2,
    REG_WIDTH   = 3'd3,
    REG_LEAD    = 3'd4,
    REG_TRAIL   = 3'd5,
    REG_GAIN    = 3'd6,
    REG_UNBOUND = 3'd7
  } cfg_reg_t;

  typedef logic signed [CH_W-1:0] chan_t;
  typedef logic signed [P_W-1:0]  prod_t;

endpackage

### hdl/pbec_chan.sv
module pbec_chan import pbec_pkg::*; #(
  parameter int CHANNEL_FRAC_BITS = 16
) (
  input  logic  clk,
  input  logic  adv,
  input  prod_t p_in,
  input  chan_t v_in,
  input  logic  wpos_in,
  input  logic  unbound,
  output chan_t v_out
);

  localparam int PH_W  = P_W - W_FRAC;
  localparam int PL_W  = W_FRAC + 1;
  localparam int MH_W  = CH_W + PH_W;
  localparam int ML_W  = CH_W + PL_W;
  localparam int RES_W = 29;
  localparam int SUM_W = 32 + RES_W;

  localparam logic signed [SUM_W-1:0] RND    = SUM_W'(64'sd1 <<< 31);
  localparam logic signed [RES_W-1:0] UNIT   = RES_W'(64'sd1 <<< CHANNEL_FRAC_BITS);
  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((64'sd1 <<< (CH_W - 1)) - 64'sd1);
  localparam logic signed [RES_W-1:0] SAT_LO = RES_W'(-(64'sd1 <<< (CH_W - 1)));

  // Multiply stage: channel times the split factor product
  logic signed [PH_W-1:0] ph;
  logic signed [PL_W-1:0] pl;
  logic signed [MH_W-1:0] mh_nxt, mh_r;
  logic signed [ML_W-1:0] ml_nxt, ml_r;
  chan_t                  v1_r;
  logic                   wpos1_r;

  assign ph     = p_in[P_W-1:W_FRAC];
  assign pl     = $signed({1'b0, p_in[W_FRAC-1:0]});
  assign mh_nxt = v_in * ph;
  assign ml_nxt = v_in * pl;

  always_ff @(posedge clk) begin
    if (adv) begin
      mh_r    <= mh_nxt;
      ml_r    <= ml_nxt;
      v1_r    <= v_in;
      wpos1_r <= wpos_in;
    end
  end

  // Add stage: v + round(v * P / 2^32), ties toward +inf
  logic signed [SUM_W-1:0] sum;
  logic signed [RES_W-1:0] res_nxt, res_r;
  chan_t                   v2_r;
  logic                    wpos2_r;

  assign sum     = (SUM_W'(mh_r) <<< W_FRAC) + SUM_W'(ml_r) + RND;
  assign res_nxt = RES_W'(v1_r) + $signed(sum[SUM_W-1:32]);

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r   <= res_nxt;
      v2_r    <= v1_r;
      wpos2_r <= wpos1_r;
    end
  end

  // Clamp stage: unit clamp when bound, then saturate to the field range; zero weight passes v through
  chan_t v_nxt, v3_r;

  always_comb begin
    logic signed [RES_W-1:0] c;
    c = res_r;
    if (!unbound) begin
      if (c < 0) c = '0;
      if (c > UNIT) c = UNIT;
    end
    if (c > SAT_HI) c = SAT_HI;
    if (c < SAT_LO) c = SAT_LO;
    v_nxt = wpos2_r ? CH_W'(c) : v2_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v3_r <= v_nxt;
    end
  end

  assign v_out = v3_r;

endmodule

### hdl/periodic_band_exposure_correction.sv
// Throughput: one pixel per clock while the skid buffer is empty; the phase remainder
//   and the feather ramp divider each resolve three bits per stage, which sets the
//   pipeline depth.
// A one-entry skid buffer behind the output register absorbs a downstream stall.
// Reset (rst_n low, synchronous): all valid bits clear, configuration registers take their defaults.
module periodic_band_exposure_correction import pbec_pkg::*; #(
  parameter int CHANNEL_FRAC_BITS  = 16,
  parameter int POSITION_FRAC_BITS = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // column[13:0], row[27:14], red_in[47:28], green_in[67:48], blue_in[87:68]
  input  logic [IN_W-1:0]       in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // red_out[19:0], green_out[39:20], blue_out[59:40], zero[63:60]
  output logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int POS_W  = COORD_W + POSITION_FRAC_BITS;
  localparam int MAG_W  = (POS_W > OFS_W) ? POS_W : OFS_W;
  localparam int MOD_ST = (MAG_W + STEPS_PER_ST - 1) / STEPS_PER_ST;
  localparam int DV_W   = FTH_W + 1;

  // Stage positions
  localparam int S_MOD   = 1;
  localparam int S_F1    = S_MOD + MOD_ST;
  localparam int S_F2    = S_F1 + 1;
  localparam int S_F3    = S_F2 + 1;
  localparam int S_DIV   = S_F3 + 1;
  localparam int S_W     = S_DIV + DIV_ST;
  localparam int S_P     = S_W + 1;
  localparam int S_CLAMP = S_P + 3;
  localparam int NST     = S_CLAMP + 1;

  // ---------------- configuration registers ----------------
  logic                 orient_r;
  logic [OFS_W-1:0]     offset_r;
  logic [PER_W-1:0]     period_r;
  logic [WID_W-1:0]     width_r;
  logic [FTH_W-1:0]     lead_r;
  logic [FTH_W-1:0]     trail_r;
  logic [GAIN_W-1:0]    gain_r;
  logic                 unbound_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      orient_r  <= 1'b0;
      offset_r  <= OFS_W'(800);
      period_r  <= PER_W'(1600);
      width_r   <= WID_W'(160);
      lead_r    <= FTH_W'(160);
      trail_r   <= FTH_W'(160);
      gain_r    <= GAIN_W'(92682);
      unbound_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORIENT:  orient_r  <= cfg_data[0];
        REG_OFFSET:  offset_r  <= cfg_data[OFS_W-1:0];
        REG_PERIOD:  period_r  <= cfg_data[PER_W-1:0];
        REG_WIDTH:   width_r   <= cfg_data[WID_W-1:0];
        REG_LEAD:    lead_r    <= cfg_data[FTH_W-1:0];
        REG_TRAIL:   trail_r   <= cfg_data[FTH_W-1:0];
        REG_GAIN:    gain_r    <= cfg_data[GAIN_W-1:0];
        REG_UNBOUND: unbound_r <= cfg_data[0];
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic            adv;
  logic [NST-1:0]  vld_r;
  logic            skid_vld_r;

  assign adv       = !skid_vld_r;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_tvalid};
    end
  end

  // Pixel delay line up to the factor stage
  logic [RGB_W-1:0] rgb_r [S_P+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rgb_r[0] <= in_tdata[2*COORD_W +: RGB_W];
      for (int i = 1; i <= S_P; i++) begin
        rgb_r[i] <= rgb_r[i-1];
      end
    end
  end

  // ---------------- stage 0: position and signed phase ----------------
  logic [COORD_W-1:0] coord;
  logic [POS_W-1:0]   pos;
  logic signed [MAG_W:0] diff;
  logic [MAG_W-1:0]   mag0_r;
  logic               neg0_r;

  assign coord = orient_r ? in_tdata[COORD_W-1:0] : in_tdata[2*COORD_W-1:COORD_W];
  assign pos   = POS_W'(coord) << POSITION_FRAC_BITS;
  assign diff  = $signed({1'b0, MAG_W'(pos)}) - $signed({1'b0, MAG_W'(offset_r)});

  always_ff @(posedge clk) begin
    if (adv) begin
      neg0_r <= diff[MAG_W];
      mag0_r <= diff[MAG_W] ? MAG_W'(-diff) : diff[MAG_W-1:0];
    end
  end

  // ---------------- remainder of |phase| by the period ----------------
  logic [PER_W-1:0] mrem_src [MOD_ST];
  logic [MAG_W-1:0] mmag_src [MOD_ST];
  logic             mneg_src [MOD_ST];
  logic [PER_W-1:0] mrem_nxt [MOD_ST];
  logic [MAG_W-1:0] mmag_nxt [MOD_ST];
  logic [PER_W-1:0] mrem_r   [MOD_ST];
  logic [MAG_W-1:0] mmag_r   [MOD_ST];
  logic             mneg_r   [MOD_ST];

  for (genvar s = 0; s < MOD_ST; s++) begin : g_mod
    if (s == 0) begin : g_head
      assign mrem_src[s] = '0;
      assign mmag_src[s] = mag0_r;
      assign mneg_src[s] = neg0_r;
    end else begin : g_body
      assign mrem_src[s] = mrem_r[s-1];
      assign mmag_src[s] = mmag_r[s-1];
      assign mneg_src[s] = mneg_r[s-1];
    end

    // Restoring remainder, one dividend bit per step
    always_comb begin
      logic [PER_W:0]   t;
      logic [PER_W-1:0] rem;
      logic [MAG_W-1:0] m;
      rem = mrem_src[s];
      m   = mmag_src[s];
      for (int k = 0; k < STEPS_PER_ST; k++) begin
        if (s * STEPS_PER_ST + k < MAG_W) begin
          t = {rem, m[MAG_W-1]};
          if (t >= {1'b0, period_r}) t = t - {1'b0, period_r};
          rem = t[PER_W-1:0];
          m   = m << 1;
        end
      end
      mrem_nxt[s] = rem;
      mmag_nxt[s] = m;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mrem_r[s] <= mrem_nxt[s];
        mmag_r[s] <= mmag_nxt[s];
        mneg_r[s] <= mneg_src[s];
      end
    end
  end

  // ---------------- fold into distance from the band center ----------------
  logic [PER_W-1:0] f1_phase_r;
  logic [PER_W-1:0] rem_last;
  logic             neg_last;

  assign rem_last = mrem_r[MOD_ST-1];
  assign neg_last = mneg_r[MOD_ST-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_phase_r <= (neg_last && rem_last != '0) ? period_r - rem_last : rem_last;
    end
  end

  // Twice the absolute distance; past half a period it counts as before the center
  logic [PER_W:0]   twice;
  logic [PER_W-1:0] back;
  logic [PER_W-1:0] f2_a2_r;
  logic             f2_dneg_r;

  assign twice = {f1_phase_r, 1'b0};
  assign back  = period_r - f1_phase_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_dneg_r <= twice > {1'b0, period_r};
      f2_a2_r   <= (twice > {1'b0, period_r}) ? {back[PER_W-2:0], 1'b0} : twice[PER_W-1:0];
    end
  end

  // Classify: full weight, zero weight, or on the ramp
  logic             full;
  logic [FTH_W-1:0] fth;
  logic [DV_W-1:0]  dv;
  logic [PER_W-1:0] over;
  logic             off;
  logic [PER_W-1:0] f3_over_r;
  logic [DV_W-1:0]  f3_dv_r;
  logic             f3_zero_r;
  logic             f3_one_r;

  assign full = f2_a2_r <= width_r;
  assign fth  = f2_dneg_r ? lead_r : trail_r;
  assign dv   = {fth, 1'b0};
  assign over = f2_a2_r - width_r;
  assign off  = (period_r == '0) || (width_r == '0);

  always_ff @(posedge clk) begin
    if (adv) begin
      f3_over_r <= over;
      f3_dv_r   <= dv;
      f3_zero_r <= off || (!full && (fth == '0 || over > PER_W'(dv)));
      f3_one_r  <= !off && full;
    end
  end

  // ---------------- ramp divider: over * 2^16 / (2 * feather) ----------------
  logic [PER_W-1:0] drem_src [DIV_ST];
  logic [Q_W-1:0]   dq_src   [DIV_ST];
  logic [DV_W-1:0]  ddv_src  [DIV_ST];
  logic             dzero_src[DIV_ST];
  logic             done_src [DIV_ST];
  logic [PER_W-1:0] drem_nxt [DIV_ST];
  logic [Q_W-1:0]   dq_nxt   [DIV_ST];
  logic [PER_W-1:0] drem_r   [DIV_ST];
  logic [Q_W-1:0]   dq_r     [DIV_ST];
  logic [DV_W-1:0]  ddv_r    [DIV_ST];
  logic             dzero_r  [DIV_ST];
  logic             done_r   [DIV_ST];

  for (genvar s = 0; s < DIV_ST; s++) begin : g_div
    if (s == 0) begin : g_head
      assign drem_src[s]  = (f3_zero_r || f3_one_r) ? '0 : f3_over_r;
      assign dq_src[s]    = '0;
      assign ddv_src[s]   = f3_dv_r;
      assign dzero_src[s] = f3_zero_r;
      assign done_src[s]  = f3_one_r;
    end else begin : g_body
      assign drem_src[s]  = drem_r[s-1];
      assign dq_src[s]    = dq_r[s-1];
      assign ddv_src[s]   = ddv_r[s-1];
      assign dzero_src[s] = dzero_r[s-1];
      assign done_src[s]  = done_r[s-1];
    end

    // Restoring division, one quotient bit per step
    always_comb begin
      logic [PER_W-1:0] rem;
      logic [PER_W-1:0] r;
      logic [Q_W-1:0]   q;
      logic             ge;
      rem = drem_src[s];
      q   = dq_src[s];
      for (int k = 0; k < STEPS_PER_ST; k++) begin
        if (s * STEPS_PER_ST + k < Q_W) begin
          ge  = rem >= PER_W'(ddv_src[s]);
          r   = ge ? rem - PER_W'(ddv_src[s]) : rem;
          q   = {q[Q_W-2:0], ge};
          rem = {r[PER_W-2:0], 1'b0};
        end
      end
      drem_nxt[s] = rem;
      dq_nxt[s]   = q;
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        drem_r[s]  <= drem_nxt[s];
        dq_r[s]    <= dq_nxt[s];
        ddv_r[s]   <= ddv_src[s];
        dzero_r[s] <= dzero_src[s];
        done_r[s]  <= done_src[s];
      end
    end
  end

  // ---------------- weight ----------------
  logic [Q_W-1:0] w_nxt, w_r;

  always_comb begin
    if (dzero_r[DIV_ST-1]) begin
      w_nxt = '0;
    end else if (done_r[DIV_ST-1]) begin
      w_nxt = W_ONE;
    end else begin
      w_nxt = W_ONE - dq_r[DIV_ST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r <= w_nxt;
    end
  end

  // ---------------- w * (gain - 1) ----------------
  logic signed [GAIN_W:0] gm;
  prod_t                  p_r;
  logic                   pw_r;

  assign gm = $signed({1'b0, gain_r}) - GAIN_ONE;

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r  <= $signed({1'b0, w_r}) * gm;
      pw_r <= w_r != '0;
    end
  end

  // ---------------- per-channel scaling ----------------
  chan_t ch_res [3];

  for (genvar c = 0; c < 3; c++) begin : g_ch
    pbec_chan #(
      .CHANNEL_FRAC_BITS(CHANNEL_FRAC_BITS)
    ) u_chan (
      .clk     (clk),
      .adv     (adv),
      .p_in    (p_r),
      .v_in    ($signed(rgb_r[S_P][c*CH_W +: CH_W])),
      .wpos_in (pw_r),
      .unbound (unbound_r),
      .v_out   (ch_res[c])
    );
  end

  // ---------------- output register and skid buffer ----------------
  logic              emit;
  logic [RGB_W-1:0]  res;
  logic [RGB_W-1:0]  o_r;
  logic [RGB_W-1:0]  skid_r;
  logic              ovld_r;

  assign emit = adv && vld_r[NST-1];
  assign res  = {ch_res[2], ch_res[1], ch_res[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r     <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (ovld_r && !out_tready) begin
      // Output held: a pixel leaving the pipe parks in the skid buffer
      if (emit) begin
        skid_vld_r <= 1'b1;
        skid_r     <= res;
      end
    end else if (skid_vld_r) begin
      ovld_r     <= 1'b1;
      o_r        <= skid_r;
      skid_vld_r <= 1'b0;
    end else begin
      ovld_r <= emit;
      o_r    <= res;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {{(OUT_W - RGB_W){1'b0}}, o_r};

endmodule

### hdl/pbec_checker.sv
module pbec_checker import pbec_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // A stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // The skid buffer only fills behind a held result, so an empty output means ready
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // Input backpressure starts only after a stalled output cycle
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input ready dropped without output stall");

endmodule

bind periodic_band_exposure_correction pbec_checker u_pbec_checker (.*);

### dv/tb_periodic_band_exposure_correction.sv
module tb_periodic_band_exposure_correction;
  timeunit 1ns;
  timeprecision 1ps;
  import pbec_pkg::*;

  localparam int     CH_FRAC     = 16;
  localparam int     POS_FRAC    = 4;
  localparam int     LATENCY     = 21;
  localparam int     HOLD_CYCLES = 300;
  localparam int     QUIET_LIMIT = 2000;
  localparam int     MAX_REPORTS = 10;
  localparam longint CH_HI       = (longint'(1) << (CH_W - 1)) - 1;
  localparam longint CH_LO       = -(longint'(1) << (CH_W - 1));
  localparam longint UNIT_V      = longint'(1) << CH_FRAC;
  localparam longint WEIGHT_ONE  = longint'(1) << W_FRAC;
  localparam longint POS_MAX     = longint'((1 << COORD_W) - 1) << POS_FRAC;

  // Predicts corrected pixels and compares them against the output stream
  class pixel_checker;
    longint orient, offset, period, width, lead, trail, gain, unbound;
    logic [OUT_W-1:0] expected_pixels[$];
    int errors;

    function new();
      orient = 0;
      offset = 800;
      period = 1600;
      width = 160;
      lead = 160;
      trail = 160;
      gain = 92682;
      unbound = 1;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_ORIENT:  orient  = val[0];
        REG_OFFSET:  offset  = val[OFS_W-1:0];
        REG_PERIOD:  period  = val[PER_W-1:0];
        REG_WIDTH:   width   = val[WID_W-1:0];
        REG_LEAD:    lead    = val[FTH_W-1:0];
        REG_TRAIL:   trail   = val[FTH_W-1:0];
        REG_GAIN:    gain    = val[GAIN_W-1:0];
        REG_UNBOUND: unbound = val[0];
        default: ;
      endcase
    endfunction

    function logic [OUT_W-1:0] corrected_pixel(logic [IN_W-1:0] d);
      logic [COORD_W-1:0] coord;
      longint pos, phase, sdist, a2, fth, w, factor, v;
      chan_t x;
      logic [OUT_W-1:0] r;
      r = '0;
      coord = (orient != 0) ? d[COORD_W-1:0] : d[2*COORD_W-1:COORD_W];
      pos = longint'(coord) << POS_FRAC;
      // band weight from the folded distance to the nearest center
      w = 0;
      if (period != 0 && width != 0) begin
        phase = (pos - offset) % period;
        if (phase < 0) phase += period;
        sdist = (2 * phase > period) ? phase - period : phase;
        a2 = 2 * ((sdist < 0) ? -sdist : sdist);
        fth = (sdist < 0) ? lead : trail;
        if (a2 <= width)
          w = WEIGHT_ONE;
        else if (fth != 0 && a2 - width <= 2 * fth)
          w = WEIGHT_ONE - ((a2 - width) * WEIGHT_ONE) / (2 * fth);
      end
      factor = (longint'(1) << 32) + w * (gain - WEIGHT_ONE);
      // scale each channel, round half up, then clamp or saturate
      for (int c = 0; c < 3; c++) begin
        x = d[2*COORD_W + CH_W*c +: CH_W];
        v = x;
        if (w > 0) begin
          v = (v * factor + (longint'(1) << 31)) >>> 32;
          if (unbound == 0) begin
            if (v < 0) v = 0;
            if (v > UNIT_V) v = UNIT_V;
          end
          if (v > CH_HI) v = CH_HI;
          if (v < CH_LO) v = CH_LO;
        end
        r[CH_W*c +: CH_W] = v[CH_W-1:0];
      end
      return r;
    endfunction

    function void note_pixel(logic [IN_W-1:0] d);
      expected_pixels.push_back(corrected_pixel(d));
    endfunction

    function void check_pixel(logic [OUT_W-1:0] got);
      logic [OUT_W-1:0] want;
      string field_name[3] = '{"red", "green", "blue"};
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("error: unexpected output pixel %h", got);
        return;
      end
      want = expected_pixels.pop_front();
      for (int c = 0; c < 3; c++) begin
        if (got[CH_W*c +: CH_W] !== want[CH_W*c +: CH_W]) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch %s: expected %0d got %0d", field_name[c],
                     $signed(want[CH_W*c +: CH_W]), $signed(got[CH_W*c +: CH_W]));
        end
      end
      if (got[OUT_W-1:RGB_W] !== want[OUT_W-1:RGB_W]) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch pad: expected %h got %h", want[OUT_W-1:RGB_W], got[OUT_W-1:RGB_W]);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // column[13:0], row[27:14], red_in[47:28], green_in[67:48], blue_in[87:68]
  logic [IN_W-1:0]       in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // red_out[19:0], green_out[39:20], blue_out[59:40], zero[63:60]
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  bit no_idle    = 1'b0;
  bit hold_req   = 1'b0;
  bit hold_taken = 1'b0;
  int hold_left  = 0;
  int quiet_cycles = 0;

  pixel_checker band_check = new();

  periodic_band_exposure_correction uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Transfer monitor and watchdog
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) band_check.set_reg(cfg_reg_t'(cfg_index), cfg_data);
    if (rst_n && in_tvalid && in_tready) band_check.note_pixel(in_tdata);
    if (rst_n && out_tvalid && out_tready) band_check.check_pixel(out_tdata);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("error: no transfer for %0d cycles", quiet_cycles);
        $display("tb_periodic_band_exposure_correction: FAIL");
        $finish;
      end
    end
  end

  // Downstream: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(0, 99) >= 26);
    end
  end

  function automatic logic [IN_W-1:0] pack_pixel(logic [COORD_W-1:0] col,
                                                 logic [COORD_W-1:0] row,
                                                 chan_t r, chan_t g, chan_t b);
    return {b, g, r, row, col};
  endfunction

  // Mix of full range, near unit range, corners and small values
  function automatic chan_t rand_channel();
    int unsigned sel;
    chan_t corner[4] = '{chan_t'(CH_HI), chan_t'(CH_LO), chan_t'(0), chan_t'(UNIT_V)};
    sel = $urandom_range(0, 99);
    if (sel < 25) return chan_t'($urandom);
    if (sel < 75) return chan_t'(int'($urandom_range(0, 90112)) - 8192);
    if (sel < 90) return corner[$urandom_range(0, 3)];
    return chan_t'(int'($urandom_range(0, 255)) - 128);
  endfunction

  // Most pixels land on or near a band so the ramps get exercised
  function automatic logic [IN_W-1:0] random_pixel();
    logic [COORD_W-1:0] col, row;
    longint span, kmin, kmax, pos;
    col = COORD_W'($urandom);
    row = COORD_W'($urandom);
    if (band_check.period != 0 && $urandom_range(0, 99) < 60) begin
      span = band_check.width / 2 + 48 +
             ((band_check.lead > band_check.trail) ? band_check.lead : band_check.trail);
      kmin = -(band_check.offset / band_check.period) - 1;
      kmax = (POS_MAX - band_check.offset) / band_check.period + 1;
      pos = band_check.offset
            + (kmin + longint'($urandom_range(0, int'(kmax - kmin)))) * band_check.period
            + longint'($urandom_range(0, int'(2 * span))) - span;
      if (pos >= 0 && pos <= POS_MAX) begin
        if (band_check.orient != 0) col = pos[POS_FRAC +: COORD_W];
        else row = pos[POS_FRAC +: COORD_W];
      end
    end
    return pack_pixel(col, row, rand_channel(), rand_channel(), rand_channel());
  endfunction

  // Offer one pixel; entered and left at a falling edge
  task automatic push_pixel(input logic [IN_W-1:0] data);
    if (!no_idle && $urandom_range(0, 99) < 26) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < 26);
    end
    in_tvalid <= 1'b1;
    in_tdata <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (band_check.expected_pixels.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Registers change only once the pipeline has emptied
  task automatic load_config(input int unsigned o, ofs, per, wid, ld, tr, g, ub);
    wait_all_results();
    write_cfg(REG_ORIENT, CFG_DATA_W'(o));
    write_cfg(REG_OFFSET, CFG_DATA_W'(ofs));
    write_cfg(REG_PERIOD, CFG_DATA_W'(per));
    write_cfg(REG_WIDTH, CFG_DATA_W'(wid));
    write_cfg(REG_LEAD, CFG_DATA_W'(ld));
    write_cfg(REG_TRAIL, CFG_DATA_W'(tr));
    write_cfg(REG_GAIN, CFG_DATA_W'(g));
    write_cfg(REG_UNBOUND, CFG_DATA_W'(ub));
    cfg_valid <= 1'b0;
  endtask

  // Center, half width edge, both ramps, ramp end, half period, coordinate extremes
  task automatic send_directed();
    int along[12] = '{50, 55, 56, 45, 44, 60, 65, 35, 66, 100, 0, 16383};
    chan_t level[6] = '{chan_t'(CH_HI), chan_t'(CH_LO), chan_t'(0), chan_t'(UNIT_V),
                        chan_t'(-1), chan_t'(40000)};
    for (int i = 0; i < 12; i++)
      push_pixel(pack_pixel(COORD_W'(along[i]), COORD_W'(along[i]), level[i % 6],
                            level[(i + 2) % 6], level[(i + 4) % 6]));
  endtask

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) push_pixel(random_pixel());
  endtask

  // Main sequence
  initial begin
    int unsigned per, wid, lim, ld, tr, g;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, then bound with column position
    send_directed();
    load_config(1, 800, 1600, 160, 160, 160, 92682, 0);
    send_directed();

    // register extremes
    load_config(1, 0, 16, 16, 0, 0, 0, 0);
    run_random(60);
    load_config(0, 160000, 32000, 24000, 8000, 8000, 2097151, 1);
    run_random(60);

    // zero period, then zero width
    load_config(0, 400, 0, 160, 160, 160, 131072, 0);
    run_random(30);
    load_config(1, 400, 1600, 0, 160, 160, 131072, 1);
    run_random(30);

    // random settings
    for (int k = 0; k < 8; k++) begin
      per = $urandom_range(0, 1) ? $urandom_range(16, 800) : $urandom_range(800, 32000);
      wid = $urandom_range(16, (per < 24000) ? per : 24000);
      lim = (per / 2 < 8000) ? per / 2 : 8000;
      ld = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, lim);
      tr = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, lim);
      g = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2097151)
                                      : $urandom_range(16384, 196608);
      load_config($urandom_range(0, 1), $urandom_range(0, 160000), per, wid, ld, tr, g,
                  $urandom_range(0, 1));
      if (k == 0) begin
        // long downstream hold-off while pixels keep coming
        run_random(40);
        hold_req = 1'b1;
        run_random(80);
      end else if (k == 1) begin
        // sender pauses until the pipeline has drained
        run_random(50);
        wait_all_results();
        run_random(50);
      end else if (k == 2) begin
        no_idle = 1'b1;
        run_random(100);
        no_idle = 1'b0;
      end else begin
        run_random(100);
      end
    end

    wait_all_results();
    repeat (2 * LATENCY) @(negedge clk);
    if (band_check.expected_pixels.size() != 0)
      $display("error: %0d pixels never came out", band_check.expected_pixels.size());
    if (band_check.errors == 0 && band_check.expected_pixels.size() == 0) begin
      $display("tb_periodic_band_exposure_correction: PASS");
    end else begin
      $display("tb_periodic_band_exposure_correction: FAIL");
    end
    $finish;
  end

endmodule

### periodic_band_exposure_correction.f
hdl/pbec_pkg.sv
hdl/pbec_chan.sv
hdl/periodic_band_exposure_correction.sv
hdl/pbec_checker.sv
dv/tb_periodic_band_exposure_correction.sv
